### design/iapl_pkg.sv
// Shared types and constants of the IEC 104 APCI link responder.
// No dependencies; imported by every module of the block.
package iapl_pkg;

    localparam int MAX_FRAME_DEF = 255;
    localparam int QDEPTH        = 4;

    localparam logic       KIND_BYTE  = 1'b0;
    localparam logic       KIND_TICK  = 1'b1;

    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] APDU_LEN_U = 8'h04;
    localparam logic [7:0] APDU_LEN_I = 8'h0E;
    localparam logic [7:0] CTRL_S     = 8'h01;
    localparam logic [7:0] TESTFR_ACT = 8'h43;
    localparam logic [7:0] TESTFR_CON = 8'h83;
    localparam logic [7:0] STARTDT_ACT = 8'h07;
    localparam logic [7:0] STARTDT_CON = 8'h0B;
    localparam logic [7:0] STOPDT_ACT = 8'h13;
    localparam logic [7:0] STOPDT_CON = 8'h23;
    localparam logic [7:0] TYPE_GI    = 8'h64;
    localparam logic [7:0] GI_VSQ     = 8'h01;
    localparam logic [7:0] COT_ACT    = 8'h06;
    localparam logic [7:0] QOI_STATION = 8'h14;

    // reply frame kinds
    typedef enum logic [1:0] {
        CMD_U    = 2'd0,
        CMD_SACK = 2'd1,
        CMD_GI   = 2'd2
    } cmd_code_t;

    // one queued reply frame
    typedef struct packed {
        cmd_code_t   code;
        logic [7:0]  ctrl;     // U frame control byte
        logic [14:0] seq_s;    // send number (GI)
        logic [14:0] seq_r;    // receive number (GI, S ack)
        logic [15:0] sid;      // common address (GI)
        logic        started;  // link state after the causing transaction
    } cmd_t;

endpackage

### design/iapl_front.sv
// Front end: frames received bytes, classifies APCI frames, updates link state
// and issues at most one reply command per transaction. Depends on iapl_pkg.
module iapl_front #(
    parameter int MAX_FRAME = iapl_pkg::MAX_FRAME_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_kind,
    input  logic [7:0]      in_byte,
    input  logic [15:0]     in_sid,
    input  logic            q_full,
    output logic            cmd_push,
    output iapl_pkg::cmd_t  cmd
);
    import iapl_pkg::*;

    localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME);

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  len_reg, len_next;
    logic [8:0]  idx_reg, idx_next;
    logic [14:0] send_reg, send_next;
    logic [14:0] recv_reg, recv_next;
    logic        started_reg, started_next;
    logic [7:0]  hdr_reg [5];
    logic [7:0]  hdr_view [5];

    logic        accept;
    logic        body_wr;
    logic [8:0]  len_calc;
    logic [8:0]  idx_plus;
    logic [7:0]  ctrl;
    logic [14:0] peer_r;
    logic [14:0] peer_s_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign body_wr  = accept && (in_kind == KIND_BYTE) && (phase_reg == PH_BODY);
    assign len_calc = {1'b0, in_byte} + 9'd2;
    assign idx_plus = idx_reg + 9'd1;

    // header bytes as seen including the byte arriving now
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            hdr_view[i] = (body_wr && idx_reg == 9'(i + 2)) ? in_byte : hdr_reg[i];
        end
    end

    assign ctrl       = hdr_view[0];
    assign peer_r     = {hdr_view[3], hdr_view[2][7:1]};
    assign peer_s_inc = {hdr_view[1], ctrl[7:1]} + 15'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        send_next    = send_reg;
        recv_next    = recv_reg;
        started_next = started_reg;
        cmd_push     = 1'b0;
        cmd.code     = CMD_U;
        cmd.ctrl     = STARTDT_ACT;
        cmd.seq_s    = send_reg;
        cmd.seq_r    = recv_reg;
        cmd.sid      = in_sid;
        if (accept)
        begin
            if (in_kind == KIND_TICK)
            begin
                cmd_push = 1'b1;
                if (started_reg)
                begin
                    cmd.code  = CMD_GI;
                    send_next = send_reg + 15'd1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (in_byte == START_BYTE)
                            phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        len_next = len_calc;
                        if (len_calc >= 9'd6 && len_calc <= MAX_LEN)
                        begin
                            phase_next = PH_BODY;
                            idx_next   = 9'd2;
                        end
                        else
                            phase_next = PH_HUNT;
                    end
                    PH_BODY:
                    begin
                        idx_next = idx_plus;
                        if (idx_plus >= len_reg)
                        begin
                            phase_next = PH_HUNT;
                            if (!ctrl[0])
                            begin
                                // I frame: adopt peer numbering, ack unless GI
                                send_next = peer_r;
                                recv_next = peer_s_inc;
                                if (!(len_reg >= 9'd7 && hdr_view[4] == TYPE_GI))
                                begin
                                    cmd_push  = 1'b1;
                                    cmd.code  = CMD_SACK;
                                    cmd.seq_r = peer_s_inc;
                                end
                            end
                            else if (ctrl[1])
                            begin
                                unique case (ctrl)
                                    TESTFR_ACT:
                                    begin
                                        cmd_push = 1'b1;
                                        cmd.ctrl = TESTFR_CON;
                                    end
                                    STARTDT_ACT:
                                    begin
                                        cmd_push     = 1'b1;
                                        cmd.ctrl     = STARTDT_CON;
                                        started_next = 1'b1;
                                        send_next    = '0;
                                        recv_next    = '0;
                                        idx_next     = '0;
                                    end
                                    STARTDT_CON:
                                    begin
                                        started_next = 1'b1;
                                        send_next    = '0;
                                        recv_next    = '0;
                                        idx_next     = '0;
                                    end
                                    STOPDT_ACT:
                                    begin
                                        cmd_push     = 1'b1;
                                        cmd.ctrl     = STOPDT_CON;
                                        started_next = 1'b0;
                                        send_next    = '0;
                                        recv_next    = '0;
                                        idx_next     = '0;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    end
                    default:
                        phase_next = PH_HUNT;
                endcase
            end
        end
        cmd.started = started_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            len_reg     <= '0;
            idx_reg     <= '0;
            send_reg    <= '0;
            recv_reg    <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            send_reg    <= send_next;
            recv_reg    <= recv_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 5; i++)
        begin
            if (body_wr && idx_reg == 9'(i + 2))
                hdr_reg[i] <= in_byte;
        end
    end

`ifndef SYNTH
    a_started_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(started_reg))
        else $error("link state changed without a transaction");
`endif

endmodule

### design/iapl_queue.sv
// Short command queue between front and back end.
// Depends on iapl_pkg for the command type and depth.
module iapl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iapl_pkg::cmd_t  wr_cmd,
    output logic            full,
    input  logic            pop,
    output logic            rd_valid,
    output iapl_pkg::cmd_t  rd_cmd
);
    import iapl_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(QDEPTH - 1);
    localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(QDEPTH);

    cmd_t          slot_reg [QDEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [AW:0]   count_reg;
    logic          wr_en, rd_en;

    assign full     = (count_reg == DEPTH_CNT);
    assign rd_valid = (count_reg != '0);
    assign wr_en    = push && !full;
    assign rd_en    = pop && rd_valid;
    assign rd_cmd   = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + AW'(1);
            if (rd_en)
                rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + AW'(1);
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + (AW + 1)'(1);
                2'b01:   count_reg <= count_reg - (AW + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rd_valid)
        else $error("pop from empty queue");
`endif

endmodule

### design/iapl_back.sv
// Back end: serializes queued reply commands into APCI frame bytes.
// Depends on iapl_pkg.
module iapl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  iapl_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);
    import iapl_pkg::*;

    cmd_t       cur_reg;
    logic       active_reg;
    logic [3:0] idx_reg;
    logic [3:0] last_idx;
    logic       is_last;

    assign last_idx = (cur_reg.code == CMD_GI) ? 4'd15 : 4'd5;
    assign is_last  = (idx_reg == last_idx);
    assign q_pop    = q_valid && (!active_reg || (m_tready && is_last));

    assign m_tvalid = active_reg;
    assign m_tlast  = is_last;
    assign m_tuser  = cur_reg.started;

    always_comb
    begin
        m_tdata = 8'h00;
        case (idx_reg)
            4'd0: m_tdata = START_BYTE;
            4'd1: m_tdata = (cur_reg.code == CMD_GI) ? APDU_LEN_I : APDU_LEN_U;
            4'd2:
            begin
                case (cur_reg.code)
                    CMD_U:    m_tdata = cur_reg.ctrl;
                    CMD_SACK: m_tdata = CTRL_S;
                    default:  m_tdata = {cur_reg.seq_s[6:0], 1'b0};
                endcase
            end
            4'd3: m_tdata = (cur_reg.code == CMD_GI) ? cur_reg.seq_s[14:7] : 8'h00;
            4'd4: m_tdata = (cur_reg.code == CMD_U) ? 8'h00 : {cur_reg.seq_r[6:0], 1'b0};
            4'd5: m_tdata = (cur_reg.code == CMD_U) ? 8'h00 : cur_reg.seq_r[14:7];
            4'd6: m_tdata = TYPE_GI;
            4'd7: m_tdata = GI_VSQ;
            4'd8: m_tdata = COT_ACT;
            4'd10: m_tdata = cur_reg.sid[7:0];
            4'd11: m_tdata = cur_reg.sid[15:8];
            4'd15: m_tdata = QOI_STATION;
            default: m_tdata = 8'h00;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (q_pop)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
        end
        else if (active_reg && m_tready)
        begin
            if (is_last)
                active_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 4'd1;
        end
    end

`ifndef SYNTH
    a_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && cur_reg.code != CMD_GI) |-> idx_reg <= 4'd5)
        else $error("short frame ran past its last byte");
    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast && !q_valid) |=> !m_tvalid)
        else $error("output valid with no frame pending");
`endif

endmodule

### design/iec104_apci_link_responder.sv
// Top level of the IEC 104 APCI link responder.
// Instantiates iapl_front, iapl_queue and iapl_back; depends on iapl_pkg.
//
// Usage:
//   Slave stream (s_*): one transaction per received link byte or call-up tick.
//     s_tuser selects the kind (0 link byte, 1 tick); s_tdata carries the
//     received byte and the station address to interrogate.
//   Master stream (m_*): reply frames, one byte per transaction, m_tlast on
//     the final byte of each frame, m_tuser the link-started flag as it stood
//     after the input transaction that caused the frame.
//   Throughput: one input transaction per cycle while the 4-entry reply
//     queue has room. Each input causes at most one reply frame (6 bytes for
//     U frames and S acks, 16 for an interrogation), drained at one byte per
//     cycle while m_tready is high. Inputs with no reply never occupy the queue.
//   Output path: a reply is written into the queue, then loaded into the
//     serializer, which raises m_tvalid once the output is idle.
//   Stalls: while m_tready is low the current byte holds; the queue absorbs
//     further replies and s_tready drops only once it is full.
//   Reset: rst_n clears framing, sequence counters, the started flag and the
//     queue at once; no clearing pass is needed.
module iec104_apci_link_responder #(
    parameter int MAX_FRAME = iapl_pkg::MAX_FRAME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] rx_byte, [23:8] station_id
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tx_byte
    output logic        m_tlast,   // tx_last
    output logic        m_tuser    // [0] link_started
);
    import iapl_pkg::*;

    cmd_t front_cmd;
    cmd_t q_cmd;
    logic cmd_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    // front end: framing and classification of received frames
    iapl_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_byte  (s_tdata[7:0]),
        .in_sid   (s_tdata[23:8]),
        .q_full   (q_full),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    // reply commands waiting for the serializer
    iapl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .wr_cmd   (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    // back end: frame byte serializer
    iapl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
